[hw/rtl/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types, constants and helpers of the rgb box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_STEP  = 64;
   localparam int HEIGHT_LIMIT  = 2048;

   localparam int PIX_W  = 8;
   localparam int SUM_W  = 20;
   localparam int WORD_W = 3 * SUM_W;
   localparam int REG_W  = 12;
   localparam int STEP_REG_W = 7;
   // compare width for the width clamp, covers the largest column count
   localparam int CLAMP_W = 14;
   // compare width for the step clamp
   localparam int STEP_CLAMP_W = 9;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_BLOCK_COLS   = 3'd2,
      REG_BLOCK_ROWS   = 3'd3,
      REG_AVERAGE_MODE = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   function automatic logic [PIX_W-1:0] sat8(input logic [SUM_W-1:0] v);
      logic [PIX_W-1:0] r;
      if (v > SUM_W'(255)) begin
         r = 8'hff;
      end else begin
         r = v[PIX_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/rbd_col_mem.sv]
// ----------------------------------------------------------------------------
// rbd_col_mem
// Column sum memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_col_mem #(
   parameter int DEPTH = rbd_pkg::DEF_MAX_WIDTH,
   parameter int AW    = $clog2(rbd_pkg::DEF_MAX_WIDTH)
) (
   input  wire logic                      clock,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [rbd_pkg::WORD_W-1:0] rd_data,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [rbd_pkg::WORD_W-1:0] wr_data
);
   import rbd_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/rbd_divider.sv]
// ----------------------------------------------------------------------------
// rbd_divider
// Three-lane restoring divider with a shared divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_divider #(
   parameter int DVW = 14
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [2:0][rbd_pkg::SUM_W-1:0]     dividend,
   input  wire logic [DVW-1:0]                     divisor,
   output logic                                    done,
   output logic      [2:0][rbd_pkg::SUM_W-1:0]     quotient
);
   import rbd_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [2:0][SUM_W-1:0] quo_ff, quo_in;
   logic [2:0][DVW-1:0]   rem_ff, rem_in;
   logic [DVW-1:0]        divisor_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [2:0][DVW:0]     trial;
   logic [2:0][DVW:0]     diff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         trial[i] = {rem_ff[i], quo_ff[i][SUM_W-1]};
         diff[i]  = trial[i] - {1'b0, divisor_ff};
         if (trial[i] >= {1'b0, divisor_ff}) begin
            rem_in[i] = diff[i][DVW-1:0];
            quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[i][DVW-1:0];
            quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
         cnt_ff     <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && cnt_ff == CNT_W'(SUM_W - 1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[hw/rtl/rgb_box_downsampler.sv]
// ----------------------------------------------------------------------------
// rgb_box_downsampler
// Box-filter downsampler for a raster RGB stream with per-column sum memory.
// ----------------------------------------------------------------------------
// a pixel is accepted in idle; its column word is read, modified and written back in
//   the modify state before the next pixel is taken. A block-closing pixel then goes
//   to emit, in average mode by way of the divide state (bit-serial divider, 20 quotient
//   bits, one per cycle); emit loads the output register, and so rsp_tvalid, once it is free
// reset: counters to zero, registers to their defaults, output empty; the column
//   memory is not cleared, the first row of each stripe overwrites it
`default_nettype none

module rgb_box_downsampler #(
   parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_STEP  = rbd_pkg::DEF_MAX_STEP
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // input pixels
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [23:0]                 req_tdata,   // red, green, blue
   // results
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [23:0]                 rsp_tdata,   // red_out, green_out, blue_out
   output logic                             rsp_tlast,   // frame_end
   output logic      [0:0]                  rsp_tuser,   // row_end
   // configuration
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [rbd_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [rbd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [rbd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import rbd_pkg::*;

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int SW  = $clog2(MAX_STEP);
   localparam int DVW = 2 * (SW + 1);
   localparam int YW  = $clog2(HEIGHT_LIMIT);

   // configuration registers
   logic [REG_W-1:0]      image_width_ff;
   logic [REG_W-1:0]      image_height_ff;
   logic [STEP_REG_W-1:0] block_cols_ff;
   logic [STEP_REG_W-1:0] block_rows_ff;
   logic                  average_mode_ff;

   // position state
   logic [XW-1:0] pixel_x_ff, pixel_x_in;
   logic [YW-1:0] pixel_y_ff, pixel_y_in;
   logic [SW-1:0] ox_ff, ox_in;
   logic [SW-1:0] oy_ff, oy_in;
   logic [XW-1:0] col_ff, col_in;

   state_type state_ff, state_in;

   logic [2:0][PIX_W-1:0] pix_ff;
   logic [2:0][PIX_W-1:0] res_ff;
   logic                  row_end_ff;
   logic                  frame_end_ff;

   logic                  out_valid_ff;
   logic [2:0][PIX_W-1:0] out_pix_ff;
   logic                  out_row_end_ff;
   logic                  out_frame_end_ff;

   // control
   logic req_accept;
   logic mem_rd_en;
   logic mem_wr_en;
   logic div_start;
   logic res_load_sample;
   logic res_load_div;
   logic out_load;

   logic [WORD_W-1:0]     rd_word;
   logic [WORD_W-1:0]     wr_word;
   logic [2:0][SUM_W-1:0] new_sum;
   logic [2:0][SUM_W:0]   add_sum;
   logic [2:0][SUM_W-1:0] quotient;
   logic                  div_done;

   // effective configuration
   logic [CLAMP_W-1:0]      w_clamp;
   logic [XW:0]             w_eff;
   logic [REG_W-1:0]        h_eff;
   logic [STEP_CLAMP_W-1:0] bc_clamp;
   logic [STEP_CLAMP_W-1:0] br_clamp;
   logic [SW:0]             bc_eff;
   logic [SW:0]             br_eff;

   logic          first_px;
   logic          row_last;
   logic          y_img_last;
   logic          frame_last;
   logic          last_x;
   logic          last_y;
   logic          emit;
   logic [SW:0]   ox_p1;
   logic [SW:0]   oy_p1;
   logic [DVW-1:0] count;

   logic csr_write;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= REG_W'(640);
         image_height_ff <= REG_W'(480);
         block_cols_ff   <= STEP_REG_W'(1);
         block_rows_ff   <= STEP_REG_W'(1);
         average_mode_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[REG_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[REG_W-1:0];
            REG_BLOCK_COLS:   block_cols_ff   <= csr_pwdata[STEP_REG_W-1:0];
            REG_BLOCK_ROWS:   block_rows_ff   <= csr_pwdata[STEP_REG_W-1:0];
            REG_AVERAGE_MODE: average_mode_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DW'(image_width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DW'(image_height_ff);
         REG_BLOCK_COLS:   csr_prdata = CSR_DW'(block_cols_ff);
         REG_BLOCK_ROWS:   csr_prdata = CSR_DW'(block_rows_ff);
         REG_AVERAGE_MODE: csr_prdata = CSR_DW'(average_mode_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // out-of-range settings act as the nearest legal value
   always_comb begin
      if (image_width_ff == '0) begin
         w_clamp = CLAMP_W'(1);
      end else if (CLAMP_W'(image_width_ff) > CLAMP_W'(MAX_WIDTH)) begin
         w_clamp = CLAMP_W'(MAX_WIDTH);
      end else begin
         w_clamp = CLAMP_W'(image_width_ff);
      end
      w_eff = w_clamp[XW:0];

      if (image_height_ff == '0) begin
         h_eff = REG_W'(1);
      end else if (image_height_ff > REG_W'(HEIGHT_LIMIT)) begin
         h_eff = REG_W'(HEIGHT_LIMIT);
      end else begin
         h_eff = image_height_ff;
      end

      if (block_cols_ff == '0) begin
         bc_clamp = STEP_CLAMP_W'(1);
      end else if (STEP_CLAMP_W'(block_cols_ff) > STEP_CLAMP_W'(MAX_STEP)) begin
         bc_clamp = STEP_CLAMP_W'(MAX_STEP);
      end else begin
         bc_clamp = STEP_CLAMP_W'(block_cols_ff);
      end
      bc_eff = bc_clamp[SW:0];

      if (block_rows_ff == '0) begin
         br_clamp = STEP_CLAMP_W'(1);
      end else if (STEP_CLAMP_W'(block_rows_ff) > STEP_CLAMP_W'(MAX_STEP)) begin
         br_clamp = STEP_CLAMP_W'(MAX_STEP);
      end else begin
         br_clamp = STEP_CLAMP_W'(block_rows_ff);
      end
      br_eff = br_clamp[SW:0];
   end

   // block position decode for the pixel in the modify cycle
   always_comb begin
      ox_p1      = {1'b0, ox_ff} + (SW+1)'(1);
      oy_p1      = {1'b0, oy_ff} + (SW+1)'(1);
      first_px   = (ox_ff == '0) && (oy_ff == '0);
      row_last   = ({1'b0, pixel_x_ff} + (XW+1)'(1)) >= w_eff;
      y_img_last = (REG_W'(pixel_y_ff) + REG_W'(1)) >= h_eff;
      frame_last = row_last && y_img_last;
      last_x     = row_last || (ox_p1 >= bc_eff);
      last_y     = y_img_last || (oy_p1 >= br_eff);
      emit       = last_x && last_y;
      count      = DVW'(ox_p1) * DVW'(oy_p1);
   end

   // read-modify-write of the column word
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         add_sum[c] = {1'b0, rd_word[c*SUM_W +: SUM_W]} + (SUM_W+1)'(pix_ff[c]);
         if (first_px) begin
            new_sum[c] = SUM_W'(pix_ff[c]);
         end else if (average_mode_ff) begin
            new_sum[c] = add_sum[c][SUM_W] ? {SUM_W{1'b1}} : add_sum[c][SUM_W-1:0];
         end else begin
            new_sum[c] = rd_word[c*SUM_W +: SUM_W];
         end
      end
      wr_word = {new_sum[2], new_sum[1], new_sum[0]};
   end

   // position update, applied at the end of the modify cycle
   always_comb begin
      pixel_x_in = pixel_x_ff;
      pixel_y_in = pixel_y_ff;
      ox_in      = ox_ff;
      oy_in      = oy_ff;
      col_in     = col_ff;
      if (row_last) begin
         pixel_x_in = '0;
         ox_in      = '0;
         col_in     = '0;
         if (frame_last) begin
            pixel_y_in = '0;
            oy_in      = '0;
         end else begin
            pixel_y_in = pixel_y_ff + YW'(1);
            oy_in      = (oy_p1 >= br_eff) ? '0 : oy_p1[SW-1:0];
         end
      end else begin
         pixel_x_in = pixel_x_ff + XW'(1);
         if (last_x) begin
            ox_in  = '0;
            col_in = col_ff + XW'(1);
         end else begin
            ox_in = ox_p1[SW-1:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (!emit) begin
               state_in = ST_IDLE;
            end else if (average_mode_ff) begin
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready      = 1'b0;
      mem_rd_en       = 1'b0;
      mem_wr_en       = 1'b0;
      div_start       = 1'b0;
      res_load_sample = 1'b0;
      res_load_div    = 1'b0;
      out_load        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            mem_rd_en  = 1'b1;
         end
         ST_MODIFY: begin
            mem_wr_en       = 1'b1;
            div_start       = emit && average_mode_ff;
            res_load_sample = emit && !average_mode_ff;
         end
         ST_DIVIDE: begin
            res_load_div = div_done;
         end
         ST_EMIT: begin
            out_load = !out_valid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pixel_x_ff <= '0;
         pixel_y_ff <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         col_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (mem_wr_en) begin
            pixel_x_ff <= pixel_x_in;
            pixel_y_ff <= pixel_y_in;
            ox_ff      <= ox_in;
            oy_ff      <= oy_in;
            col_ff     <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_ff[0] <= req_tdata[7:0];
         pix_ff[1] <= req_tdata[15:8];
         pix_ff[2] <= req_tdata[23:16];
      end
      if (mem_wr_en && emit) begin
         row_end_ff   <= row_last;
         frame_end_ff <= frame_last;
      end
      if (res_load_sample) begin
         for (int c = 0; c < 3; c++) res_ff[c] <= sat8(new_sum[c]);
      end else if (res_load_div) begin
         for (int c = 0; c < 3; c++) res_ff[c] <= sat8(quotient[c]);
      end
   end

   // output register, holds one result while the core moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pix_ff       <= res_ff;
         out_row_end_ff   <= row_end_ff;
         out_frame_end_ff <= frame_end_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_pix_ff[2], out_pix_ff[1], out_pix_ff[0]};
   assign rsp_tlast    = out_frame_end_ff;
   assign rsp_tuser[0] = out_row_end_ff;

   rbd_col_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (XW)
   ) u_col_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (col_ff),
      .rd_data (rd_word),
      .wr_en   (mem_wr_en),
      .wr_addr (col_ff),
      .wr_data (wr_word)
   );

   rbd_divider #(
      .DVW (DVW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_sum),
      .divisor  (count),
      .done     (div_done),
      .quotient (quotient)
   );

`ifndef SYNTHESIS
   // every accepted pixel is written back in the following cycle
   a_accept_then_write: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> mem_wr_en)
      else $error("accepted pixel not written back");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(out_load && out_valid_ff && !rsp_tready))
      else $error("result overwritten before transfer");

   // the frame end always closes an output row
   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[0])
      else $error("frame end without row end");

   // no pixel is taken while a block result is being divided
   a_no_accept_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !req_tready)
      else $error("pixel accepted during division");
`endif

endmodule

`default_nettype wire

[verif/box_average_checker.sv]
// ----------------------------------------------------------------------------
// box_average_checker
// Follows register writes and pixel transfers of the rgb box downsampler,
// predicts every block result and compares each result transfer with it.
// ----------------------------------------------------------------------------
module box_average_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   input  wire logic [23:0]                 req_tdata,   // red, green, blue
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic [23:0]                 rsp_tdata,   // red_out, green_out, blue_out
   input  wire logic                        rsp_tlast,   // frame_end
   input  wire logic [0:0]                  rsp_tuser,   // row_end
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [rbd_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [rbd_pkg::CSR_DW-1:0]  csr_pwdata,
   input  wire logic                        csr_pready,
   output int unsigned                      mismatches,
   output int unsigned                      results_open
);
   timeunit 1ns;
   timeprecision 1ps;

   import rbd_pkg::*;

   localparam int unsigned SUM_LIMIT = 32'h000f_ffff;
   localparam int unsigned PRINT_CAP = 50;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             row_end;
      logic             frame_end;
   } block_result_type;

   block_result_type block_results_due[$];

   // running channel sums (or the sampled pixel) per output column
   logic [SUM_W-1:0]      column_total [DEF_MAX_WIDTH][3];

   logic [REG_W-1:0]      image_width;
   logic [REG_W-1:0]      image_height;
   logic [STEP_REG_W-1:0] block_cols;
   logic [STEP_REG_W-1:0] block_rows;
   logic                  average_mode;

   logic [10:0]           pixel_col;
   logic [10:0]           pixel_row;
   logic [5:0]            block_x;
   logic [5:0]            block_y;
   logic [10:0]           output_col;

   function automatic int unsigned effective_size(input int unsigned raw,
                                                  input int unsigned hi);
      if (raw == 0) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned seen,
                                input int unsigned due);
      if (mismatches < PRINT_CAP) begin
         $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, seen, due);
      end
      mismatches++;
   endtask

   task automatic fold_pixel(input logic [23:0] pix);
      int unsigned      w, h, bc, br, count, value;
      int               c;
      logic [PIX_W-1:0] chan [3];
      logic [PIX_W-1:0] mean [3];
      logic             row_last, frame_last, last_x, last_y;
      block_result_type res;
      w  = effective_size(image_width, DEF_MAX_WIDTH);
      h  = effective_size(image_height, HEIGHT_LIMIT);
      bc = effective_size(block_cols, DEF_MAX_STEP);
      br = effective_size(block_rows, DEF_MAX_STEP);
      chan[0] = pix[7:0];
      chan[1] = pix[15:8];
      chan[2] = pix[23:16];
      for (c = 0; c < 3; c++) begin
         if (block_x == 0 && block_y == 0) begin
            column_total[output_col][c] = SUM_W'(chan[c]);
         end else if (average_mode) begin
            value = column_total[output_col][c] + chan[c];
            column_total[output_col][c] = (value > SUM_LIMIT) ? SUM_W'(SUM_LIMIT)
                                                              : SUM_W'(value);
         end
      end
      row_last   = (pixel_col + 1 >= w);
      frame_last = row_last && (pixel_row + 1 >= h);
      last_x     = row_last || (block_x + 1 >= bc);
      last_y     = (pixel_row + 1 >= h) || (block_y + 1 >= br);
      if (last_x && last_y) begin
         // clipped blocks divide by the pixels actually seen
         count = (block_x + 1) * (block_y + 1);
         for (c = 0; c < 3; c++) begin
            value = average_mode ? column_total[output_col][c] / count
                                 : column_total[output_col][c];
            mean[c] = (value > 255) ? 8'hff : value[7:0];
         end
         res.red       = mean[0];
         res.green     = mean[1];
         res.blue      = mean[2];
         res.row_end   = row_last;
         res.frame_end = frame_last;
         block_results_due.push_back(res);
      end
      if (row_last) begin
         pixel_col  = '0;
         block_x    = '0;
         output_col = '0;
         if (frame_last) begin
            pixel_row = '0;
            block_y   = '0;
         end else begin
            pixel_row = pixel_row + 1'b1;
            block_y   = (block_y + 1 >= br) ? 6'd0 : block_y + 1'b1;
         end
      end else begin
         pixel_col = pixel_col + 1'b1;
         if (last_x) begin
            block_x    = '0;
            output_col = output_col + 1'b1;
         end else begin
            block_x = block_x + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      block_result_type due;
      if (reset) begin
         image_width  = 12'd640;
         image_height = 12'd480;
         block_cols   = 7'd1;
         block_rows   = 7'd1;
         average_mode = 1'b1;
         pixel_col    = '0;
         pixel_row    = '0;
         block_x      = '0;
         block_y      = '0;
         output_col   = '0;
         block_results_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_IMAGE_WIDTH:  image_width  = csr_pwdata[REG_W-1:0];
               REG_IMAGE_HEIGHT: image_height = csr_pwdata[REG_W-1:0];
               REG_BLOCK_COLS:   block_cols   = csr_pwdata[STEP_REG_W-1:0];
               REG_BLOCK_ROWS:   block_rows   = csr_pwdata[STEP_REG_W-1:0];
               REG_AVERAGE_MODE: average_mode = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (block_results_due.size() == 0) begin
               flag_mismatch("result with none expected", rsp_tdata, 0);
            end else begin
               due = block_results_due.pop_front();
               if (rsp_tdata[7:0] !== due.red) begin
                  flag_mismatch("red_out", rsp_tdata[7:0], due.red);
               end
               if (rsp_tdata[15:8] !== due.green) begin
                  flag_mismatch("green_out", rsp_tdata[15:8], due.green);
               end
               if (rsp_tdata[23:16] !== due.blue) begin
                  flag_mismatch("blue_out", rsp_tdata[23:16], due.blue);
               end
               if (rsp_tuser[0] !== due.row_end) begin
                  flag_mismatch("row_end", rsp_tuser[0], due.row_end);
               end
               if (rsp_tlast !== due.frame_end) begin
                  flag_mismatch("frame_end", rsp_tlast, due.frame_end);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            fold_pixel(req_tdata);
         end
      end
      results_open <= block_results_due.size();
   end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives pixel frames of many geometries and both modes into the rgb box
// downsampler, with random gaps and stalls and register changes mid-frame;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rbd_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 32;
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned RANDOM_PIXELS = 750;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata   = '0;   // red, green, blue
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [23:0]         rsp_tdata;          // red_out, green_out, blue_out
   logic                rsp_tlast;          // frame_end
   logic [0:0]          rsp_tuser;          // row_end
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   int unsigned         mismatches;
   int unsigned         results_open;
   int unsigned         quiet_cycles = 0;
   int unsigned         fill_pixels  = 0;
   int unsigned         frame_w;
   int unsigned         frame_h;
   int unsigned         phase;
   bit                  calm    = 1'b0;
   bit                  hold_go = 1'b0;

   logic [23:0] corner_pixels [12] = '{
      24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00,
      24'hff0000, 24'hffffff, 24'hffffff, 24'hffffff,
      24'h55aa55, 24'haa55aa, 24'h000000, 24'hfffffe
   };

   rgb_box_downsampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   box_average_checker block_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .mismatches   (mismatches),
      .results_open (results_open)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("** rgb_box_downsampler: FAILED **");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= calm || ($urandom_range(99) >= 23);
      end
   end

   function automatic int unsigned effective(input int unsigned raw, input int unsigned hi);
      if (raw == 0) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   function automatic int unsigned pick_size(input int unsigned common_hi,
                                             input int unsigned rare_hi);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) return 0;
      if (roll < 88) return $urandom_range(common_hi, 1);
      return $urandom_range(rare_hi, common_hi + 1);
   endfunction

   function automatic int unsigned pick_step();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return 0;
      if (roll < 75) return $urandom_range(6, 1);
      if (roll < 90) return $urandom_range(64, 7);
      return $urandom_range(127, 65);
   endfunction

   // leaves psel high; the caller closes the burst of writes
   task automatic write_reg(input reg_index_type idx, input int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      // junk above the register bits must be ignored
      csr_pwdata  <= {($urandom_range(1) != 0) ? 20'($urandom) : 20'd0, 12'(value)};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, h, bc, br, input logic avg);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_BLOCK_COLS, bc);
      write_reg(REG_BLOCK_ROWS, br);
      write_reg(REG_AVERAGE_MODE, avg);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      frame_w = effective(w, DEF_MAX_WIDTH);
      frame_h = effective(h, HEIGHT_LIMIT);
   endtask

   task automatic change_reg(input reg_index_type idx, input int unsigned value);
      write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // all results in, then time for a block with no result still in flight
   task automatic wait_idle();
      while (results_open != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_pixel(input logic [23:0] pix);
      if (!calm) begin
         while ($urandom_range(99) < 23) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random(input int unsigned n);
      repeat (n) send_pixel(24'($urandom));
      end_burst();
   endtask

   // one frame with a register change part way through it
   task automatic split_frame(input logic avg);
      int unsigned knob, cut, raw, total, rest;
      knob  = $urandom_range(2);
      total = frame_w * frame_h;
      if (knob == 1 && frame_h >= 2) begin
         // new height at a row start; a row at or past it closes the frame
         cut = $urandom_range(frame_h - 1, 1);
         send_random(cut * frame_w);
         wait_idle();
         raw = $urandom_range(frame_h + 4);
         change_reg(REG_IMAGE_HEIGHT, raw);
         frame_h = effective(raw, HEIGHT_LIMIT);
         rest = frame_w * ((frame_h > cut) ? frame_h - cut : 1);
         send_random(rest);
         fill_pixels += cut * frame_w + rest;
      end else if (knob == 2 && frame_w >= 2) begin
         // narrower width inside the first row, so every column word is fresh
         cut = $urandom_range(frame_w - 1, 1);
         send_random(cut);
         wait_idle();
         raw = $urandom_range(cut);
         change_reg(REG_IMAGE_WIDTH, raw);
         frame_w = effective(raw, DEF_MAX_WIDTH);
         rest = 1 + (frame_h - 1) * frame_w;
         send_random(rest);
         fill_pixels += cut + rest;
      end else if (total >= 2) begin
         cut = $urandom_range(total - 1, 1);
         send_random(cut);
         wait_idle();
         change_reg(REG_AVERAGE_MODE, !avg);
         send_random(total - cut);
         fill_pixels += total;
      end else begin
         send_random(total);
         fill_pixels += total;
      end
   endtask

   task automatic random_phase();
      int unsigned w, h, bc, br, frames;
      logic        avg;
      w   = pick_size(24, 48);
      h   = pick_size(10, 20);
      bc  = pick_step();
      br  = pick_step();
      avg = $urandom_range(1);
      wait_idle();
      set_geometry(w, h, bc, br, avg);
      if ($urandom_range(3) == 0) begin
         split_frame(avg);
      end else begin
         frames = (frame_w * frame_h > 256) ? 1 : $urandom_range(2, 1);
         send_random(frames * frame_w * frame_h);
         fill_pixels += frames * frame_w * frame_h;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // channel extremes over full and clipped 2x2 blocks
      set_geometry(4, 3, 2, 2, 1);
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      end_burst();

      // average to sample inside a block: the raw sum saturates the output
      wait_idle();
      set_geometry(2, 2, 2, 2, 1);
      repeat (3) send_pixel(24'hffffff);
      end_burst();
      wait_idle();
      change_reg(REG_AVERAGE_MODE, 0);
      send_pixel(24'h808080);
      end_burst();

      // sample to average inside a block
      wait_idle();
      set_geometry(2, 2, 2, 2, 0);
      send_pixel(24'h102030);
      send_pixel(24'hffffff);
      end_burst();
      wait_idle();
      change_reg(REG_AVERAGE_MODE, 1);
      send_pixel(24'hf0e0d0);
      send_pixel(24'h0f0e0d);
      end_burst();

      // zero registers act as one: every pixel is a whole frame
      wait_idle();
      set_geometry(0, 0, 0, 0, 1);
      send_random(3);
      // width above the maximum, then a zero width closes the row early
      wait_idle();
      set_geometry(4095, 1, 1, 0, 0);
      send_random(100);
      wait_idle();
      change_reg(REG_IMAGE_WIDTH, 0);
      send_random(1);
      // tall frame with steps above the maximum, cut short by a zero height
      wait_idle();
      set_geometry(0, 4095, 127, 127, 1);
      send_random(130);
      wait_idle();
      change_reg(REG_IMAGE_HEIGHT, 0);
      send_random(1);
      // no idling on either side for a whole frame
      wait_idle();
      calm = 1'b1;
      set_geometry(70, 3, 127, 1, 1);
      send_random(frame_w * frame_h);
      calm = 1'b0;
      wait_idle();
      set_geometry(5, 7, 64, 64, 1);
      send_random(frame_w * frame_h);

      // receiver holds off while a result per pixel piles up
      wait_idle();
      set_geometry(8, 8, 1, 1, 0);
      hold_go = 1'b1;
      send_random(frame_w * frame_h);

      phase = 0;
      while (fill_pixels < RANDOM_PIXELS) begin
         calm = (phase >= 4 && phase < 8);
         random_phase();
         phase++;
      end
      calm = 1'b0;

      wait_idle();
      if (mismatches == 0) begin
         $display("** rgb_box_downsampler: PASSED **");
      end else begin
         $display("** rgb_box_downsampler: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_col_mem.sv
hw/rtl/rbd_divider.sv
hw/rtl/rgb_box_downsampler.sv
verif/box_average_checker.sv
verif/testbench.sv
